/* design/ctxp_pkg.sv */
// ----------------------------------------------------------------------------
// ctxp_pkg
// Shared types and constants of the chained table xor packet cipher: queue
// entry layouts, key constants and the divider step count.
// ----------------------------------------------------------------------------
package ctxp_pkg;

   // key schedule constants
   localparam logic [31:0] KEY_STEP = 32'h2E6D23C1;
   localparam logic [31:0] NEXT_ADD = 32'h08088405;

   // full block width in bytes
   localparam logic [2:0] FULL_BYTES = 3'd4;

   // a data word with this byte count is dropped
   localparam logic [2:0] NO_BYTES = 3'd0;

   // request word kinds
   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_DATA = 1'b1
   } func_code_type;

   // request queue between front and back
   localparam int FQ_DEPTH = 4;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);
   localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

   // result queue at the output
   localparam int OQ_DEPTH = 2;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   // restoring divider, one quotient bit a cycle over a 32-bit dividend
   localparam int          DIV_STEPS = 32;
   localparam int          DIV_CW    = $clog2(DIV_STEPS + 1);

   // classified request word
   typedef struct packed {
      logic        is_load;
      logic [7:0]  table_addr;
      logic [31:0] word;
      logic [2:0]  byte_count;
      logic        first;
      logic [13:0] total_blocks;
      logic [31:0] start_key;
      logic        last;
   } req_entry_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } fq_head_type;

   // result word
   typedef struct packed {
      logic [31:0] out_word;
      logic [2:0]  out_bytes;
      logic        out_last;
      logic [31:0] next_key;
   } rsp_entry_type;

   // mask of the valid low bytes of a tail word
   function automatic logic [31:0] byte_keep(input logic [2:0] count);
      logic [31:0] keep;
      case (count)
         3'd1: keep = 32'h0000_00FF;
         3'd2: keep = 32'h0000_FFFF;
         3'd3: keep = 32'h00FF_FFFF;
         default: keep = 32'hFFFF_FFFF;
      endcase
      return keep;
   endfunction

endpackage

/* design/ctxp_div.sv */
// ----------------------------------------------------------------------------
// ctxp_div
// Restoring divider giving the remainder of a 32-bit dividend, one bit per
// cycle. Divisor is latched at start; done pulses once the remainder is held.
// ----------------------------------------------------------------------------
module ctxp_div
   import ctxp_pkg::*;
#(
   parameter int DVW = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      dividend,
   input  logic [DVW-1:0]   divisor,
   output logic             done,
   output logic [DVW-1:0]   remainder
);

   logic [31:0]       quo_ff,  quo_in;
   logic [DVW-1:0]    rem_ff,  rem_in;
   logic [DVW-1:0]    dvs_ff,  dvs_in;
   logic [DIV_CW-1:0] cnt_ff,  cnt_in;
   logic              done_ff, done_in;
   logic [DVW:0]      trial;
   logic [DVW:0]      diff;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = DIV_CW'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[30:0], 1'b0};
         rem_in  = (trial >= {1'b0, dvs_ff}) ? diff[DVW-1:0] : trial[DVW-1:0];
         cnt_in  = cnt_ff - DIV_CW'(1);
         done_in = (cnt_ff == DIV_CW'(1));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* design/ctxp_front.sv */
// ----------------------------------------------------------------------------
// ctxp_front
// Accepts request words, drops empty data words, clamps the byte count and
// queues the classified word for the back end.
// ----------------------------------------------------------------------------
module ctxp_front
   import ctxp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [7:0]  req_table_addr,
   input  logic [31:0] req_table_word,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_first,
   input  logic [13:0] req_total_blocks,
   input  logic [31:0] req_start_key,
   input  logic        req_last,
   output fq_head_type head,
   input  logic        head_pop
);

   req_entry_type     fq_mem [FQ_DEPTH];
   logic [FQ_AW-1:0]  wp_ff,  wp_in;
   logic [FQ_AW-1:0]  rp_ff,  rp_in;
   logic [FQ_CW-1:0]  cnt_ff, cnt_in;
   req_entry_type     entry;
   logic              store;
   logic              deq;

   // classify the incoming word
   always_comb begin
      entry.is_load      = (req_func == FUNC_LOAD);
      entry.table_addr   = req_table_addr;
      entry.word         = (req_func == FUNC_DATA) ? req_data_word : req_table_word;
      entry.byte_count   = (req_byte_count > FULL_BYTES) ? FULL_BYTES : req_byte_count;
      entry.first        = req_first;
      entry.total_blocks = req_total_blocks;
      entry.start_key    = req_start_key;
      entry.last         = req_last;
   end

   assign req_full = (cnt_ff == FQ_CW'(FQ_DEPTH));
   assign store    = req_push & ~req_full
                     & ~((req_func == FUNC_DATA) & (req_byte_count == NO_BYTES));
   assign deq      = head_pop & (cnt_ff != '0);

   // queue pointers
   always_comb begin
      wp_in  = store ? wp_ff + FQ_AW'(1) : wp_ff;
      rp_in  = deq ? rp_ff + FQ_AW'(1) : rp_ff;
      cnt_in = cnt_ff + FQ_CW'(store) - FQ_CW'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (store) begin
         fq_mem[wp_ff] <= entry;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.entry = fq_mem[rp_ff];

endmodule

/* design/ctxp_back.sv */
// ----------------------------------------------------------------------------
// ctxp_back
// Carries out queued words: key table writes, the chained key schedule with
// its table index remainder, the xor and the result queue.
// ----------------------------------------------------------------------------
module ctxp_back
   import ctxp_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int MAX_BLOCKS  = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [8:0]  table_size,
   input  fq_head_type head,
   output logic        head_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_out_word,
   output logic [2:0]  rsp_out_bytes,
   output logic        rsp_out_last,
   output logic [31:0] rsp_next_key
);

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int TW  = $clog2(TABLE_DEPTH + 1);
   localparam int DVW = (TW > 9) ? TW : 9;

   // reciprocals for the constant wraps of load address and block count
   localparam int ADDR_W     = 8;
   localparam int BLK_W      = 14;
   localparam int ADDR_RECIP = (1 << ADDR_W) / TABLE_DEPTH;
   localparam int BLK_RECIP  = (1 << BLK_W) / MAX_BLOCKS;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_KSTART = 5'b00010,
      S_KDIV   = 5'b00100,
      S_READ   = 5'b01000,
      S_OUT    = 5'b10000
   } back_state_type;

   back_state_type   state_ff, state_in;
   req_entry_type    cur_ff, cur_in;
   logic [31:0]      chained_ff, chained_in;
   logic [31:0]      entry_key_ff, entry_key_in;
   logic [CW-1:0]    countdown_ff, countdown_in;
   logic [31:0]      rdata_ff;
   logic [31:0]      key_mem [TABLE_DEPTH];
   logic [CW-1:0]    ctr;
   logic [DVW-1:0]   eff_size;
   logic [31:0]      addr_q;
   logic [31:0]      addr_rem;
   logic [31:0]      blk_q;
   logic [31:0]      blk_rem;
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [31:0]      mem_wd;
   logic [AW-1:0]    mem_ra;
   logic             div_start;
   logic [31:0]      div_dividend;
   logic [DVW-1:0]   div_divisor;
   logic             div_done;
   logic [DVW-1:0]   div_rem;
   logic             oq_push;
   rsp_entry_type    oq_wdata;
   logic             oq_full;
   logic [31:0]      new_key;
   logic [31:0]      tail_mask;

   rsp_entry_type    oq_mem [OQ_DEPTH];
   logic [OQ_AW-1:0] oq_wp_ff, oq_wp_in;
   logic [OQ_AW-1:0] oq_rp_ff, oq_rp_in;
   logic [OQ_CW-1:0] oq_cnt_ff, oq_cnt_in;
   logic             oq_deq;

   // effective table size, clamped to one and to the table depth
   always_comb begin
      if (table_size == 9'd0) begin
         eff_size = DVW'(1);
      end else if (DVW'(table_size) > DVW'(TABLE_DEPTH)) begin
         eff_size = DVW'(TABLE_DEPTH);
      end else begin
         eff_size = DVW'(table_size);
      end
   end

   // constant wraps: reciprocal multiply, then one compare and subtract
   always_comb begin
      addr_q   = (32'(head.entry.table_addr) * 32'(ADDR_RECIP)) >> ADDR_W;
      addr_rem = 32'(head.entry.table_addr) - addr_q * 32'(TABLE_DEPTH);
      if (addr_rem >= 32'(TABLE_DEPTH)) begin
         addr_rem = addr_rem - 32'(TABLE_DEPTH);
      end
      blk_q   = (32'(head.entry.total_blocks) * 32'(BLK_RECIP)) >> BLK_W;
      blk_rem = 32'(head.entry.total_blocks) - blk_q * 32'(MAX_BLOCKS);
      if (blk_rem >= 32'(MAX_BLOCKS)) begin
         blk_rem = blk_rem - 32'(MAX_BLOCKS);
      end
   end

   // counter step down with wrap
   assign ctr = (countdown_ff == '0) ? CW'(MAX_BLOCKS - 1) : countdown_ff - CW'(1);

   // shared remainder unit
   ctxp_div #(
      .DVW (DVW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign mem_ra    = AW'(div_rem);
   assign new_key   = rdata_ff + KEY_STEP;
   assign tail_mask = chained_ff ^ rdata_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      chained_in   = chained_ff;
      entry_key_in = entry_key_ff;
      countdown_in = countdown_ff;
      head_pop     = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = eff_size;
      mem_we       = 1'b0;
      mem_wa       = AW'(addr_rem);
      mem_wd       = head.entry.word;
      oq_push      = 1'b0;
      oq_wdata     = '0;
      case (state_ff)
         S_IDLE: begin
            if (head.valid && head.entry.is_load) begin
               // key table write at the wrapped address
               head_pop = 1'b1;
               mem_we   = 1'b1;
            end else if (head.valid && !oq_full) begin
               head_pop = 1'b1;
               cur_in   = head.entry;
               state_in = S_KSTART;
               if (head.entry.first) begin
                  chained_in   = head.entry.start_key;
                  entry_key_in = head.entry.start_key;
                  countdown_in = CW'(blk_rem);
               end
            end
         end
         S_KSTART: begin
            div_start = 1'b1;
            if (cur_ff.byte_count == FULL_BYTES) begin
               div_dividend = 32'(ctr) + chained_ff;
               countdown_in = ctr;
            end else begin
               div_dividend = 32'(cur_ff.byte_count);
            end
            state_in = S_KDIV;
         end
         S_KDIV: begin
            // table word is read on the edge that ends this state
            if (div_done) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            oq_push            = 1'b1;
            oq_wdata.out_last  = cur_ff.last;
            oq_wdata.out_bytes = cur_ff.byte_count;
            if (cur_ff.byte_count == FULL_BYTES) begin
               chained_in        = new_key;
               oq_wdata.out_word = cur_ff.word ^ new_key;
            end else begin
               oq_wdata.out_word = (cur_ff.word ^ tail_mask) & byte_keep(cur_ff.byte_count);
            end
            if (cur_ff.last) begin
               oq_wdata.next_key = ({entry_key_ff[26:0], 5'b0} - entry_key_ff) + NEXT_ADD;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chained_ff   <= '0;
         entry_key_ff <= '0;
         countdown_ff <= '0;
      end else begin
         state_ff     <= state_in;
         chained_ff   <= chained_in;
         entry_key_ff <= entry_key_in;
         countdown_ff <= countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // key table, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= key_mem[mem_ra];
   end

   // result queue
   assign oq_full   = (oq_cnt_ff == OQ_CW'(OQ_DEPTH));
   assign rsp_empty = (oq_cnt_ff == '0);
   assign oq_deq    = rsp_pop & ~rsp_empty;

   always_comb begin
      oq_wp_in  = oq_push ? oq_wp_ff + OQ_AW'(1) : oq_wp_ff;
      oq_rp_in  = oq_deq ? oq_rp_ff + OQ_AW'(1) : oq_rp_ff;
      oq_cnt_in = oq_cnt_ff + OQ_CW'(oq_push) - OQ_CW'(oq_deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wp_ff  <= '0;
         oq_rp_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wp_ff  <= oq_wp_in;
         oq_rp_ff  <= oq_rp_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_mem[oq_wp_ff] <= oq_wdata;
      end
   end

   assign rsp_out_word  = oq_mem[oq_rp_ff].out_word;
   assign rsp_out_bytes = oq_mem[oq_rp_ff].out_bytes;
   assign rsp_out_last  = oq_mem[oq_rp_ff].out_last;
   assign rsp_next_key  = oq_mem[oq_rp_ff].next_key;

endmodule

/* design/chained_table_xor_packet_cipher_top.sv */
// a data word goes through the key start, remainder and read states, where it
//    enters the result queue, and the output state; the 32-step remainder unit
//    forms every table index, so no data word is taken until the back end idles
// a key table load is written in the idle state as it is popped
// reset: synchronous, clears queues, key state and sets table_size to 256;
//    the key table itself is not cleared and must be loaded before use
// ----------------------------------------------------------------------------
// chained_table_xor_packet_cipher_top
// Packet scrambler top level: front end queue, back end key schedule and the
// table size control register.
// ----------------------------------------------------------------------------
module chained_table_xor_packet_cipher_top
   import ctxp_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int MAX_BLOCKS  = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [7:0]  req_table_addr,
   input  logic [31:0] req_table_word,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_first,
   input  logic [13:0] req_total_blocks,
   input  logic [31:0] req_start_key,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_out_word,
   output logic [2:0]  rsp_out_bytes,
   output logic        rsp_out_last,
   output logic [31:0] rsp_next_key,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_wdata
);

   localparam logic [8:0] TABLE_SIZE_RESET = 9'd256;

   logic [8:0]  table_size_ff, table_size_in;
   fq_head_type head;
   logic        head_pop;

   // table size register, always ready for a word
   assign csr_ready     = 1'b1;
   assign table_size_in = (csr_valid && csr_ready) ? csr_wdata : table_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // accept and classify
   ctxp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_table_addr   (req_table_addr),
      .req_table_word   (req_table_word),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_first        (req_first),
      .req_total_blocks (req_total_blocks),
      .req_start_key    (req_start_key),
      .req_last         (req_last),
      .head             (head),
      .head_pop         (head_pop)
   );

   // key schedule and scrambling
   ctxp_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_BLOCKS  (MAX_BLOCKS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .table_size    (table_size_ff),
      .head          (head),
      .head_pop      (head_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_word  (rsp_out_word),
      .rsp_out_bytes (rsp_out_bytes),
      .rsp_out_last  (rsp_out_last),
      .rsp_next_key  (rsp_next_key)
   );

endmodule

/* bench/ctxp_scramble_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctxp_scramble_checker
// Watches the request, result and control channels of the packet cipher,
// keeps its own key table and key chain, works out every scrambled word
// and compares it field by field with what leaves the result queue.
// ----------------------------------------------------------------------------
module ctxp_scramble_checker
   import ctxp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_func,
   input  logic [7:0]  req_table_addr,
   input  logic [31:0] req_table_word,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_first,
   input  logic [13:0] req_total_blocks,
   input  logic [31:0] req_start_key,
   input  logic        req_last,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_out_word,
   input  logic [2:0]  rsp_out_bytes,
   input  logic        rsp_out_last,
   input  logic [31:0] rsp_next_key,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [8:0]  csr_wdata,
   output int          mismatch_count,
   output int          due_count,
   output int          words_checked
);

   localparam int TABLE_ENTRIES = 256;

   // own copy of the key state
   logic [31:0]   key_tab [TABLE_ENTRIES];
   logic [8:0]    size_reg;
   logic [31:0]   chain_key;
   logic [31:0]   packet_key;
   logic [13:0]   blocks_left;

   // scrambled words still to come, oldest first
   rsp_entry_type scrambled_due[$];
   rsp_entry_type oldest;

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s at %0t: expected %h, got %h", what, $time, want, got);
   endtask

   // work out the scrambled word for one accepted request, if it makes one
   task automatic scramble_word();
      logic [31:0]   modulus;
      logic [2:0]    nbytes;
      logic [13:0]   ctr;
      logic [31:0]   idx;
      logic [31:0]   keep;
      rsp_entry_type w;
      if (req_func == FUNC_LOAD) begin
         key_tab[req_table_addr] = req_table_word;
         return;
      end
      if (req_byte_count == NO_BYTES)
         return;
      nbytes = (req_byte_count > FULL_BYTES) ? FULL_BYTES : req_byte_count;
      if (size_reg == 9'd0)
         modulus = 32'd1;
      else if (size_reg > TABLE_ENTRIES)
         modulus = TABLE_ENTRIES;
      else
         modulus = 32'(size_reg);
      if (req_first) begin
         chain_key   = req_start_key;
         packet_key  = req_start_key;
         blocks_left = req_total_blocks;
      end
      if (nbytes == FULL_BYTES) begin
         // countdown wraps below zero, key chains through the table
         ctr         = blocks_left - 14'd1;
         idx         = (32'(ctr) + chain_key) % modulus;
         chain_key   = key_tab[idx] + KEY_STEP;
         w.out_word  = req_data_word ^ chain_key;
         blocks_left = ctr;
      end else begin
         // short tail: chain untouched, unused bytes cleared
         idx        = 32'(nbytes) % modulus;
         keep       = (32'd1 << (8 * int'(nbytes))) - 32'd1;
         w.out_word = (req_data_word ^ chain_key ^ key_tab[idx]) & keep;
      end
      w.out_bytes = nbytes;
      w.out_last  = req_last;
      w.next_key  = req_last ? (packet_key * 32'd31 + NEXT_ADD) : 32'd0;
      scrambled_due.push_back(w);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scrambled_due.delete();
         size_reg       = 9'd256;
         chain_key      = '0;
         packet_key     = '0;
         blocks_left    = '0;
         mismatch_count = 0;
         words_checked  = 0;
      end else begin
         // compare a popped word with the oldest prediction
         if (!rsp_empty && rsp_pop) begin
            if (scrambled_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("word %h at %0t with nothing expected", rsp_out_word, $time);
            end else begin
               oldest = scrambled_due.pop_front();
               words_checked++;
               if (rsp_out_word !== oldest.out_word)
                  report("out_word", oldest.out_word, rsp_out_word);
               if (rsp_out_bytes !== oldest.out_bytes)
                  report("out_bytes", 32'(oldest.out_bytes), 32'(rsp_out_bytes));
               if (rsp_out_last !== oldest.out_last)
                  report("out_last", 32'(oldest.out_last), 32'(rsp_out_last));
               if (rsp_next_key !== oldest.next_key)
                  report("next_key", oldest.next_key, rsp_next_key);
            end
         end
         // table size register
         if (csr_valid && csr_ready)
            size_reg = csr_wdata;
         // accepted request
         if (req_push && !req_full)
            scramble_word();
      end
      due_count <= scrambled_due.size();
   end

endmodule

/* bench/chained_table_xor_packet_cipher_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_table_xor_packet_cipher_top_tb
// Fills the key table, runs a directed set of packets and corner words, then
// random packets, loads and stray words under several table sizes, with
// random gaps on both queues; a checker beside the block scores each word.
// ----------------------------------------------------------------------------
module chained_table_xor_packet_cipher_top_tb;
   import ctxp_pkg::*;

   // settle time before a register write and at the end: covers a slow
   //    data word with margin
   localparam int SETTLE_CYCLES = 120;
   localparam int PHASE_WORDS   = 230;
   localparam int PHASES        = 7;

   typedef struct packed {
      logic        func;
      logic [7:0]  table_addr;
      logic [31:0] table_word;
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        first;
      logic [13:0] total_blocks;
      logic [31:0] start_key;
      logic        last;
   } req_word_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_push         = 1'b0;
   logic        req_func         = 1'b0;
   logic [7:0]  req_table_addr   = '0;
   logic [31:0] req_table_word   = '0;
   logic [31:0] req_data_word    = '0;
   logic [2:0]  req_byte_count   = '0;
   logic        req_first        = 1'b0;
   logic [13:0] req_total_blocks = '0;
   logic [31:0] req_start_key    = '0;
   logic        req_last         = 1'b0;
   logic        rsp_pop          = 1'b0;
   logic        csr_valid        = 1'b0;
   logic [8:0]  csr_wdata        = '0;
   logic        req_full;
   logic        rsp_empty;
   logic [31:0] rsp_out_word;
   logic [2:0]  rsp_out_bytes;
   logic        rsp_out_last;
   logic [31:0] rsp_next_key;
   logic        csr_ready;

   int mismatches;
   int words_due;
   int words_checked;
   int words_pushed = 0;
   int stall_left   = 0;
   bit gaps_on      = 1'b1;
   bit push_gaps    = 1'b1;

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   chained_table_xor_packet_cipher_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_table_addr   (req_table_addr),
      .req_table_word   (req_table_word),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_first        (req_first),
      .req_total_blocks (req_total_blocks),
      .req_start_key    (req_start_key),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_word     (rsp_out_word),
      .rsp_out_bytes    (rsp_out_bytes),
      .rsp_out_last     (rsp_out_last),
      .rsp_next_key     (rsp_next_key),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   ctxp_scramble_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_table_addr   (req_table_addr),
      .req_table_word   (req_table_word),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_first        (req_first),
      .req_total_blocks (req_total_blocks),
      .req_start_key    (req_start_key),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_word     (rsp_out_word),
      .rsp_out_bytes    (rsp_out_bytes),
      .rsp_out_last     (rsp_out_last),
      .rsp_next_key     (rsp_next_key),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatches),
      .due_count        (words_due),
      .words_checked    (words_checked)
   );

   // result side: pop with random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // random 32-bit value, leaning on the extremes now and then
   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type random_req();
      req_word_type r;
      r.func         = 1'($urandom);
      r.table_addr   = 8'($urandom);
      r.table_word   = $urandom;
      r.data_word    = $urandom;
      r.byte_count   = 3'($urandom);
      r.first        = 1'($urandom);
      r.total_blocks = 14'($urandom);
      r.start_key    = $urandom;
      r.last         = 1'($urandom);
      return r;
   endfunction

   // offer one word, with an occasional gap in front of it
   task automatic push_word(input req_word_type w);
      if (gaps_on && push_gaps && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_func         <= w.func;
      req_table_addr   <= w.table_addr;
      req_table_word   <= w.table_word;
      req_data_word    <= w.data_word;
      req_byte_count   <= w.byte_count;
      req_first        <= w.first;
      req_total_blocks <= w.total_blocks;
      req_start_key    <= w.start_key;
      req_last         <= w.last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      words_pushed++;
   endtask

   task automatic load_entry(input logic [7:0] addr, input logic [31:0] value);
      req_word_type w;
      w            = random_req();
      w.func       = FUNC_LOAD;
      w.table_addr = addr;
      w.table_word = value;
      push_word(w);
   endtask

   task automatic send_data(input logic [2:0] count, input bit first, input bit last,
                            input logic [13:0] blocks, input logic [31:0] key);
      req_word_type w;
      w            = random_req();
      w.func       = FUNC_DATA;
      w.data_word  = pick32();
      w.byte_count = count;
      w.first      = first;
      w.last       = last;
      if (first) begin
         w.total_blocks = blocks;
         w.start_key    = key;
      end
      push_word(w);
   endtask

   // full blocks then an optional tail of 1 to 3 bytes
   task automatic send_packet(input int nblocks, input int tail, input logic [31:0] key,
                              input logic [13:0] blocks_field);
      logic [2:0] full;
      for (int i = 0; i < nblocks; i++) begin
         full = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : FULL_BYTES;
         send_data(full, i == 0, (tail == 0) && (i == nblocks - 1), blocks_field, key);
      end
      if (tail != 0)
         send_data(3'(tail), nblocks == 0, 1'b1, blocks_field, key);
   endtask

   // register write once all words are out and the back end has settled
   task automatic write_table_size(input logic [8:0] setting);
      req_push <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= setting;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well formed packets, some loads and stray words
   task automatic run_random_phase(input int target);
      int           done;
      int           kind;
      int           nblocks;
      int           tail;
      req_word_type w;
      done = 0;
      while (done < target) begin
         push_gaps = ($urandom_range(0, 4) != 0);
         kind      = $urandom_range(0, 99);
         if (kind < 10) begin
            load_entry(8'($urandom), pick32());
            done++;
         end else if (kind < 22) begin
            w           = random_req();
            w.func      = FUNC_DATA;
            w.data_word = pick32();
            push_word(w);
            if (w.byte_count != NO_BYTES)
               done++;
         end else begin
            nblocks = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
            tail    = $urandom_range(0, 3);
            if (nblocks == 0 && tail == 0)
               tail = $urandom_range(1, 3);
            send_packet(nblocks, tail, pick32(),
                        ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'(nblocks));
            done += nblocks + ((tail != 0) ? 1 : 0);
         end
      end
   endtask

   // stimulus
   initial begin
      logic [8:0] setting;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_table_size(9'd256);

      // data before any first word, counter wrapping from zero onto the top entry
      load_entry(8'd255, pick32());
      send_data(FULL_BYTES, 1'b0, 1'b0, 14'($urandom), $urandom);

      // fill the whole table so that every size reads written entries
      for (int a = 0; a < 256; a++)
         load_entry(8'(a), (a == 0) ? 32'h0000_0000 : (a == 255) ? 32'hFFFF_FFFF : $urandom);

      // directed packets and corner words
      send_packet(2, 3, 32'hFFFF_FFFF, 14'd2);
      send_packet(0, 1, 32'h0000_0000, 14'd0);
      send_packet(0, 2, $urandom, 14'd0);
      send_data(NO_BYTES, 1'b1, 1'b1, 14'($urandom), $urandom);
      send_data(3'd5, 1'b1, 1'b0, 14'd1, $urandom);
      send_data(3'd7, 1'b0, 1'b1, 14'd0, 32'd0);
      send_data(FULL_BYTES, 1'b1, 1'b1, 14'd0, $urandom);
      send_data(FULL_BYTES, 1'b1, 1'b0, 14'h3FFF, 32'hFFFF_FFFF);
      send_data(FULL_BYTES, 1'b0, 1'b1, 14'd0, 32'd0);
      // tail arriving before the blocks run out
      send_data(FULL_BYTES, 1'b1, 1'b0, 14'd3, $urandom);
      send_data(3'd1, 1'b0, 1'b1, 14'd0, 32'd0);
      // more blocks than the count
      send_data(FULL_BYTES, 1'b1, 1'b0, 14'd1, $urandom);
      send_data(FULL_BYTES, 1'b0, 1'b0, 14'd0, 32'd0);
      send_data(3'd6, 1'b0, 1'b1, 14'd0, 32'd0);
      load_entry(8'd0, 32'h0000_0000);

      // random phases over a range of table sizes, the last without gaps
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: setting = 9'd256;
            1: setting = 9'd1;
            2: setting = 9'd0;
            3: setting = 9'h1FF;
            4: setting = 9'($urandom_range(2, 255));
            5: setting = 9'($urandom_range(257, 510));
            default: setting = 9'($urandom_range(1, 256));
         endcase
         write_table_size(setting);
         gaps_on = (p < PHASES - 1);
         run_random_phase(PHASE_WORDS);
      end

      // drain
      req_push <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d request words and %0d checked scrambled words", words_pushed,
               words_checked);
      $display("table sizes 256, 1, 0, 511 and random ones, with stray and broken packets");
      if (mismatches == 0 && words_due == 0) begin
         $display("chained_table_xor_packet_cipher_top_tb: clean");
      end else begin
         $display("chained_table_xor_packet_cipher_top_tb: errors");
      end
      $finish;
   end

   // watchdog: several times the slowest legal run
   initial begin
      #8_000_000;
      $display("timed out with %0d words outstanding", words_due);
      $display("chained_table_xor_packet_cipher_top_tb: errors");
      $finish;
   end

endmodule

/* files.f */
design/ctxp_pkg.sv
design/ctxp_div.sv
design/ctxp_front.sv
design/ctxp_back.sv
design/chained_table_xor_packet_cipher_top.sv
bench/ctxp_scramble_checker.sv
bench/chained_table_xor_packet_cipher_top_tb.sv
